// ===== sv/mpwsd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpwsd_pkg
// shared command codes and control types for the work-stealing deque block
// ----------------------------------------------------------------------------
package mpwsd_pkg;

	localparam int CMD_W  = 3;
	localparam int PIPE_W = 3;

	localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STEAL = 3'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

	// decision taken for one command at its transfer
	typedef struct packed {
		logic ok;     // command succeeded
		logic empty;  // pipe empty after the command
		logic rd;     // slot read issued (successful pop or steal)
		logic wr;     // slot write issued (successful push)
	} mpwsd_dec_t;

endpackage

// ===== sv/mpwsd_ram.sv =====
// ----------------------------------------------------------------------------
// mpwsd_ram
// generic single-port synchronous ram with registered read
// ----------------------------------------------------------------------------
module mpwsd_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [WIDTH-1:0]  wdata,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// ===== sv/mpwsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpwsd_ctrl
// per-pipe front/back positions, command decode and slot address generation
// ----------------------------------------------------------------------------
module mpwsd_ctrl #(
	parameter int SLOTS_LOG2 = 8,
	parameter int NUM_PIPES  = 8,
	parameter int PIDX_W     = 3
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic [mpwsd_pkg::CMD_W-1:0]  command,
	input  logic [mpwsd_pkg::PIPE_W-1:0] pipe,
	output mpwsd_pkg::mpwsd_dec_t        dec,
	output logic [PIDX_W+SLOTS_LOG2-1:0] addr
);

	import mpwsd_pkg::*;

	localparam int POS_W = SLOTS_LOG2 + 1;
	localparam int CMP_W = 8;

	logic [POS_W-1:0]  front_q [NUM_PIPES];
	logic [POS_W-1:0]  back_q  [NUM_PIPES];
	logic [PIDX_W-1:0] pidx;
	logic              pipe_ok;
	logic [POS_W-1:0]  front_cur, back_cur, front_dec, fill, fill_m1;
	logic              full, is_empty;
	logic [POS_W-1:0]  slot_pos;

	assign pidx      = PIDX_W'(pipe);
	assign pipe_ok   = CMP_W'(pipe) < CMP_W'(NUM_PIPES);
	assign front_cur = pipe_ok ? front_q[pidx] : '0;
	assign back_cur  = pipe_ok ? back_q[pidx] : '0;
	assign front_dec = front_cur - POS_W'(1);
	assign fill      = front_cur - back_cur;
	assign fill_m1   = fill - POS_W'(1);
	assign full      = fill[SLOTS_LOG2];
	assign is_empty  = (fill == '0);

	always_comb begin
		dec      = '0;
		dec.empty = is_empty;
		slot_pos = front_cur;
		unique case (command)
			CMD_PUSH: begin
				dec.ok    = !full;
				dec.wr    = !full;
				dec.empty = 1'b0;
				slot_pos  = front_cur;
				if (full) begin
					dec.empty = is_empty;
				end
			end
			CMD_POP: begin
				dec.ok    = !is_empty;
				dec.rd    = !is_empty;
				dec.empty = is_empty || (fill_m1 == '0);
				slot_pos  = front_dec;
			end
			CMD_STEAL: begin
				dec.ok    = !is_empty;
				dec.rd    = !is_empty;
				dec.empty = is_empty || (fill_m1 == '0);
				slot_pos  = back_cur;
			end
			CMD_CLEAR: begin
				dec.ok    = 1'b1;
				dec.empty = 1'b1;
			end
			default: begin
				// query and unused codes leave the pipe alone
				dec.empty = is_empty;
			end
		endcase
		if (!pipe_ok) begin
			dec = '{ok: 1'b0, empty: 1'b1, rd: 1'b0, wr: 1'b0};
		end
	end

	assign addr = {pidx, slot_pos[SLOTS_LOG2-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PIPES; i++) begin
				front_q[i] <= '0;
				back_q[i]  <= '0;
			end
		end else if (fire && pipe_ok) begin
			case (command)
				CMD_PUSH: begin
					if (!full) front_q[pidx] <= front_cur + POS_W'(1);
				end
				CMD_POP: begin
					if (!is_empty) front_q[pidx] <= front_dec;
				end
				CMD_STEAL: begin
					if (!is_empty) back_q[pidx] <= back_cur + POS_W'(1);
				end
				CMD_CLEAR: begin
					front_q[pidx] <= '0;
					back_q[pidx]  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== sv/multi_pipe_work_stealing_deque.sv =====
// ----------------------------------------------------------------------------
// multi_pipe_work_stealing_deque
// bounded double-ended task pipes sharing one slot ram, one command per item
// ----------------------------------------------------------------------------
// results: push, query, clear and failed commands show their result in the cycle
//   after the input transfer; a successful pop or steal shows it after the
//   registered slot read and the read state; throughput: one item per cycle
//   while the result side keeps up, except a successful pop or steal, which waits for the slot read
// reset: all front and back positions go to zero at once, so every pipe is
//   empty; slot contents are undefined until pushed and need no clearing pass
// ----------------------------------------------------------------------------
module multi_pipe_work_stealing_deque #(
	parameter int SLOTS_LOG2   = 8,
	parameter int NUM_PIPES    = 8,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mpwsd_pkg::CMD_W-1:0]  command,
	input  logic [mpwsd_pkg::PIPE_W-1:0] pipe,
	input  logic [PAYLOAD_BITS-1:0]      payload_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         ok,
	output logic [PAYLOAD_BITS-1:0]      payload_out,
	output logic                         empty_res
);

	import mpwsd_pkg::*;

	// pipe index width; at least one bit so a single pipe still addresses
	localparam int PIDX_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
	localparam int ADDR_W = PIDX_W + SLOTS_LOG2;
	localparam int DEPTH  = 1 << ADDR_W;

	// sequencer states
	localparam logic [0:0] S_IDLE = 1'b0;
	localparam logic [0:0] S_READ = 1'b1;

	logic [0:0]              state_q;
	logic                    in_fire;
	mpwsd_dec_t              dec;
	logic [ADDR_W-1:0]       addr;
	logic [PAYLOAD_BITS-1:0] rdata;
	logic                    empty_s1;

	// result register
	logic                    out_valid_q;
	logic                    ok_q;
	logic                    empty_q;
	logic [PAYLOAD_BITS-1:0] payload_q;

	// take a new item when no read is in flight and the result register is
	// free by the next edge
	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_fire  = in_valid && in_ready;

	mpwsd_ctrl #(
		.SLOTS_LOG2 (SLOTS_LOG2),
		.NUM_PIPES  (NUM_PIPES),
		.PIDX_W     (PIDX_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (in_fire),
		.command (command),
		.pipe    (pipe),
		.dec     (dec),
		.addr    (addr)
	);

	// slot store: push writes at the front, pop and steal read one slot
	mpwsd_ram #(
		.WIDTH  (PAYLOAD_BITS),
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_slots (
		.clk   (clk),
		.en    (in_fire && (dec.rd || dec.wr)),
		.we    (dec.wr),
		.addr  (addr),
		.wdata (payload_in),
		.rdata (rdata)
	);

	// sequencer: a successful pop or steal waits in S_READ for the slot read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && dec.rd) state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// empty flag of a pending read, kept for the cycle the data arrives
	always_ff @(posedge clk) begin
		if (in_fire) empty_s1 <= dec.empty;
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_fire && !dec.rd) || (state_q == S_READ)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (in_fire && !dec.rd) begin
			ok_q      <= dec.ok;
			empty_q   <= dec.empty;
			payload_q <= '0;
		end else if (state_q == S_READ) begin
			// reads are only issued for a successful pop or steal
			ok_q      <= 1'b1;
			empty_q   <= empty_s1;
			payload_q <= rdata;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign empty_res   = empty_q;
	assign payload_out = payload_q;

	// the result register is always free while a slot read is pending
	a_read_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> !out_valid_q)
		else $error("result register busy during slot read");

	// a pending read turns into a result on the next edge
	a_read_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (out_valid_q && ok_q && (state_q == S_IDLE)))
		else $error("slot read did not produce a result");

	// a transfer that issues a read is followed by the read state
	a_rd_enters_read: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && dec.rd) |=> (state_q == S_READ))
		else $error("pop or steal did not enter read state");

	// a slot access is never both a read and a write
	a_rd_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> !(dec.rd && dec.wr))
		else $error("slot read and write issued together");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for multi_pipe_work_stealing_deque: a directed table,
// then random per-pipe command runs and one deep fill/drain pass; a shadow
// deque predicts every result and the bench compares them in transfer order
// ----------------------------------------------------------------------------
module testbench;
	import mpwsd_pkg::*;

	localparam int SLOTS_LOG2   = 8;
	localparam int NUM_PIPES    = 8;
	localparam int PAYLOAD_BITS = 64;
	localparam int SLOT_COUNT   = 1 << SLOTS_LOG2;
	localparam int POS_W        = SLOTS_LOG2 + 1;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	// command codes the package leaves unnamed; the block must ignore them
	localparam logic [CMD_W-1:0] CMD_UNUSED5 = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED7 = 3'd7;

	localparam logic [PAYLOAD_BITS-1:0] WORD_ONES = '1;

	typedef struct packed {
		logic                    ok;
		logic [PAYLOAD_BITS-1:0] payload;
		logic                    empty;
	} deque_result_t;

	// one directed command; rows with known = 1 carry a hand-typed answer
	typedef struct {
		logic [CMD_W-1:0]        cmd;
		logic [PIPE_W-1:0]       pid;
		logic [PAYLOAD_BITS-1:0] word;
		bit                      known;
		logic                    want_ok;
		logic [PAYLOAD_BITS-1:0] want_payload;
		logic                    want_empty;
	} directed_row_t;

	// ------------------------------------------------------------------------
	// block ports, all inputs known from time zero
	// ------------------------------------------------------------------------
	logic                    clk;
	logic                    arst_n     = 1'b0;
	logic                    in_valid   = 1'b0;
	logic                    in_ready;
	logic [CMD_W-1:0]        command    = CMD_QUERY;
	logic [PIPE_W-1:0]       pipe       = '0;
	logic [PAYLOAD_BITS-1:0] payload_in = '0;
	logic                    out_valid;
	logic                    out_ready  = 1'b0;
	logic                    ok;
	logic [PAYLOAD_BITS-1:0] payload_out;
	logic                    empty_res;

	multi_pipe_work_stealing_deque #(
		.SLOTS_LOG2   (SLOTS_LOG2),
		.NUM_PIPES    (NUM_PIPES),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.pipe        (pipe),
		.payload_in  (payload_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ok          (ok),
		.payload_out (payload_out),
		.empty_res   (empty_res)
	);

	// ------------------------------------------------------------------------
	// shadow deque state and the results still owed by the block
	// ------------------------------------------------------------------------
	logic [POS_W-1:0]        shadow_front [NUM_PIPES];
	logic [POS_W-1:0]        shadow_back  [NUM_PIPES];
	logic [PAYLOAD_BITS-1:0] shadow_slots [NUM_PIPES*SLOT_COUNT];
	deque_result_t           owed_results [$];

	int sender_gap_pct  = 0;  // chance per item of a cycle with valid low
	int receiver_stall_pct = 0;  // chance per cycle of ready low
	int commands_sent   = 0;
	int results_checked = 0;
	int error_count     = 0;
	int cycle_count     = 0;

	// positions wrap at 2^(SLOTS_LOG2+1), so the difference is the fill count
	function automatic logic [POS_W-1:0] pipe_fill(input logic [PIPE_W-1:0] pid);
		return shadow_front[pid] - shadow_back[pid];
	endfunction

	// applies one command to the shadow deque and returns what the block owes
	function automatic deque_result_t apply_deque_command(input logic [CMD_W-1:0] cmd,
			input logic [PIPE_W-1:0] pid, input logic [PAYLOAD_BITS-1:0] word);
		deque_result_t res;
		int            base;
		res = '{ok: 1'b0, payload: '0, empty: 1'b1};
		if (int'(pid) < NUM_PIPES) begin
			base = int'(pid) * SLOT_COUNT;
			case (cmd)
				CMD_PUSH: begin
					if (pipe_fill(pid) < SLOT_COUNT) begin
						shadow_slots[base + int'(shadow_front[pid][SLOTS_LOG2-1:0])] = word;
						shadow_front[pid] = shadow_front[pid] + 1'b1;
						res.ok = 1'b1;
					end
				end
				CMD_POP: begin
					// newest entry sits just below the front position
					if (pipe_fill(pid) != 0) begin
						shadow_front[pid] = shadow_front[pid] - 1'b1;
						res.payload = shadow_slots[base + int'(shadow_front[pid][SLOTS_LOG2-1:0])];
						res.ok = 1'b1;
					end
				end
				CMD_STEAL: begin
					// oldest entry sits at the back position
					if (pipe_fill(pid) != 0) begin
						res.payload = shadow_slots[base + int'(shadow_back[pid][SLOTS_LOG2-1:0])];
						shadow_back[pid] = shadow_back[pid] + 1'b1;
						res.ok = 1'b1;
					end
				end
				CMD_CLEAR: begin
					shadow_front[pid] = '0;
					shadow_back[pid]  = '0;
					res.ok = 1'b1;
				end
				default: begin
					// query and the unused codes change nothing
				end
			endcase
			res.empty = (pipe_fill(pid) == 0);
		end
		return res;
	endfunction

	// mostly random words, now and then the all-zero and all-one extremes
	function automatic logic [PAYLOAD_BITS-1:0] random_task_word();
		case ($urandom_range(15))
			0:       return '0;
			1:       return WORD_ONES;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// clock and cycle limit
	// ------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycle_count,
				owed_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// result side: random back-pressure and in-order checking
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_results.size() == 0) begin
				$error("result transfer with nothing owed: ok=%0d payload_out=%h empty_res=%0d",
					ok, payload_out, empty_res);
				error_count++;
			end else begin
				want = owed_results.pop_front();
				results_checked++;
				if (ok !== want.ok) begin
					$error("ok mismatch: expected %0d, actual %0d", want.ok, ok);
					error_count++;
				end
				if (payload_out !== want.payload) begin
					$error("payload_out mismatch: expected %h, actual %h", want.payload,
						payload_out);
					error_count++;
				end
				if (empty_res !== want.empty) begin
					$error("empty_res mismatch: expected %0d, actual %0d", want.empty,
						empty_res);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// command side
	// ------------------------------------------------------------------------

	// holds valid until the transfer, then records what the block owes;
	// a known row replaces the shadow answer but the shadow state still moves
	task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [PIPE_W-1:0] pid,
			input logic [PAYLOAD_BITS-1:0] word, input bit known, input deque_result_t want);
		deque_result_t predicted;
		while ($urandom_range(99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		pipe       <= pid;
		payload_in <= word;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// transfer happened at this edge
		predicted = apply_deque_command(cmd, pid, word);
		owed_results.push_back(known ? want : predicted);
		commands_sent++;
	endtask

	// short runs of commands on one pipe at a time, biased toward pushes so
	// pipes hold entries and pops and steals mostly succeed
	task automatic run_pipe_traffic(input int command_total);
		int               issued;
		int               pick;
		logic [PIPE_W-1:0] pid;
		logic [CMD_W-1:0]  cmd;
		issued = 0;
		while (issued < command_total) begin
			pid = PIPE_W'($urandom_range(NUM_PIPES-1));
			repeat ($urandom_range(1, 12)) begin
				pick = $urandom_range(99);
				if (pick < 48)      cmd = CMD_PUSH;
				else if (pick < 66) cmd = CMD_POP;
				else if (pick < 84) cmd = CMD_STEAL;
				else if (pick < 92) cmd = CMD_QUERY;
				else if (pick < 95) cmd = CMD_CLEAR;
				else begin
					case ($urandom_range(2))
						0:       cmd = CMD_UNUSED5;
						1:       cmd = CMD_UNUSED6;
						default: cmd = CMD_UNUSED7;
					endcase
				end
				issue_command(cmd, pid, random_task_word(), 1'b0, '0);
				issued++;
			end
		end
	endtask

	// directed table: reset state, field extremes, ordering of pop and steal,
	// clear, and the unused codes; last rows are left to the shadow deque
	directed_row_t directed_rows [25] = '{
		'{CMD_POP,     3'd0, 64'h0,                 1'b1, 1'b0, 64'h0,                 1'b1},
		'{CMD_STEAL,   3'd7, 64'h0,                 1'b1, 1'b0, 64'h0,                 1'b1},
		'{CMD_QUERY,   3'd3, 64'h0,                 1'b1, 1'b0, 64'h0,                 1'b1},
		'{CMD_CLEAR,   3'd5, 64'h0,                 1'b1, 1'b1, 64'h0,                 1'b1},
		'{CMD_UNUSED5, 3'd0, WORD_ONES,             1'b1, 1'b0, 64'h0,                 1'b1},
		'{CMD_PUSH,    3'd0, 64'h0,                 1'b1, 1'b1, 64'h0,                 1'b0},
		'{CMD_PUSH,    3'd0, WORD_ONES,             1'b1, 1'b1, 64'h0,                 1'b0},
		'{CMD_PUSH,    3'd0, 64'h8000000000000001,  1'b1, 1'b1, 64'h0,                 1'b0},
		'{CMD_QUERY,   3'd0, 64'h0,                 1'b1, 1'b0, 64'h0,                 1'b0},
		'{CMD_UNUSED6, 3'd0, 64'h0,                 1'b1, 1'b0, 64'h0,                 1'b0},
		'{CMD_POP,     3'd0, 64'h0,                 1'b1, 1'b1, 64'h8000000000000001,  1'b0},
		'{CMD_STEAL,   3'd0, 64'h0,                 1'b1, 1'b1, 64'h0,                 1'b0},
		'{CMD_POP,     3'd0, 64'h0,                 1'b1, 1'b1, WORD_ONES,             1'b1},
		'{CMD_POP,     3'd0, 64'h0,                 1'b1, 1'b0, 64'h0,                 1'b1},
		'{CMD_PUSH,    3'd7, 64'h5555555555555555,  1'b1, 1'b1, 64'h0,                 1'b0},
		'{CMD_PUSH,    3'd7, 64'hAAAAAAAAAAAAAAAA,  1'b1, 1'b1, 64'h0,                 1'b0},
		'{CMD_UNUSED7, 3'd7, 64'h0,                 1'b1, 1'b0, 64'h0,                 1'b0},
		'{CMD_CLEAR,   3'd7, 64'h0,                 1'b1, 1'b1, 64'h0,                 1'b1},
		'{CMD_STEAL,   3'd7, 64'h0,                 1'b1, 1'b0, 64'h0,                 1'b1},
		'{CMD_PUSH,    3'd7, 64'h0123456789ABCDEF,  1'b1, 1'b1, 64'h0,                 1'b0},
		'{CMD_STEAL,   3'd7, 64'h0,                 1'b1, 1'b1, 64'h0123456789ABCDEF,  1'b1},
		'{CMD_PUSH,    3'd3, 64'hFEDCBA9876543210,  1'b0, 1'b0, 64'h0,                 1'b0},
		'{CMD_PUSH,    3'd3, 64'h0F0F0F0F0F0F0F0F,  1'b0, 1'b0, 64'h0,                 1'b0},
		'{CMD_STEAL,   3'd3, 64'h0,                 1'b0, 1'b0, 64'h0,                 1'b0},
		'{CMD_POP,     3'd3, 64'h0,                 1'b0, 1'b0, 64'h0,                 1'b0}
	};

	initial begin
		logic [PIPE_W-1:0] deep_pipe;
		deque_result_t     typed_answer;

		// reset clears every position, so every shadow pipe starts empty
		for (int p = 0; p < NUM_PIPES; p++) begin
			shadow_front[p] = '0;
			shadow_back[p]  = '0;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phase one: sender rarely idles, receiver stalls about half the time
		sender_gap_pct     = 8;
		receiver_stall_pct = 49;
		foreach (directed_rows[i]) begin
			typed_answer = '{ok: directed_rows[i].want_ok, payload: directed_rows[i].want_payload,
				empty: directed_rows[i].want_empty};
			issue_command(directed_rows[i].cmd, directed_rows[i].pid, directed_rows[i].word,
				directed_rows[i].known, typed_answer);
		end
		run_pipe_traffic(100);

		// phase two: roles swapped; one pipe is filled, rejected, drained,
		// rejected, then filled again so the front position wraps to zero
		// while the back sits at half range, which must still read as full
		sender_gap_pct     = 49;
		receiver_stall_pct = 8;
		deep_pipe = PIPE_W'($urandom_range(NUM_PIPES-1));
		issue_command(CMD_CLEAR, deep_pipe, '0, 1'b0, '0);
		while (pipe_fill(deep_pipe) < SLOT_COUNT)
			issue_command(CMD_PUSH, deep_pipe, random_task_word(), 1'b0, '0);
		issue_command(CMD_PUSH, deep_pipe, random_task_word(), 1'b0, '0);
		while (pipe_fill(deep_pipe) != 0)
			issue_command(CMD_STEAL, deep_pipe, '0, 1'b0, '0);
		issue_command(CMD_STEAL, deep_pipe, '0, 1'b0, '0);
		while (pipe_fill(deep_pipe) < SLOT_COUNT)
			issue_command(CMD_PUSH, deep_pipe, random_task_word(), 1'b0, '0);
		issue_command(CMD_PUSH, deep_pipe, random_task_word(), 1'b0, '0);
		// take from both ends across the slot wrap, then throw the rest away
		repeat (24)
			issue_command($urandom_range(1) ? CMD_POP : CMD_STEAL, deep_pipe, '0, 1'b0, '0);
		issue_command(CMD_CLEAR, deep_pipe, '0, 1'b0, '0);
		run_pipe_traffic(60);

		// phase three: no idling on either side, back-to-back transfers
		sender_gap_pct     = 0;
		receiver_stall_pct = 0;
		run_pipe_traffic(100);
		in_valid <= 1'b0;

		// let owed results arrive, then watch for strays
		while (owed_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d commands over %0d pipes, %0d results checked, %0d mismatches",
			commands_sent, NUM_PIPES, results_checked, error_count);
		$display("covered empty, full and cleared pipes, position wrap, three stall mixes");
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
